// ----- rtl/rlfs_pkg.sv -----
`default_nettype none
package rlfs_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 256;
  localparam int unsigned COUNT_W        = 9;
  localparam int unsigned POS_W          = 10;
  localparam int unsigned PIXEL_W        = 24;

  localparam logic [COUNT_W-1:0] PIXEL_COUNT_RST = 9'd150;

  // command kinds carried on in_tuser
  localparam logic [2:0] KIND_WRITE = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_FILL  = 3'd2;
  localparam logic [2:0] KIND_START = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  localparam logic RESULT_READBACK = 1'b0;
  localparam logic RESULT_TX_WORD  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    RSP_READBACK,
    RSP_PIXEL,
    RSP_ZERO,
    RSP_LAST
  } rsp_kind_t;

  // pending result handed from the sequencer to the output stage
  typedef struct packed {
    logic      valid;
    rsp_kind_t kind;
    logic      black;
  } rsp_req_t;

endpackage
`default_nettype wire

// ----- rtl/rgb_led_frame_store_serializer.sv -----
`default_nettype none
// RGB LED frame store and strand serializer. Pixels (24-bit RGB) live in one
// single-port-write, registered-read memory of MAX_PIXELS entries. Commands
// arrive on the in_ stream with the command kind on in_tuser: write a pixel,
// read a pixel back, fill the first pixel_count pixels with one color, start a
// frame, and tick. While a frame is being sent each tick returns one 4-byte
// word: an all-zero opening word, one word per pixel (flag, blue, green, red),
// and an all-zero closing word with out_tlast set. Write, fill and start are
// dropped while a frame is in progress; reads are still answered. After reset
// the store is cleared to black, entry by entry, while in_tready stays low
// (config writes are still taken). Write, start and ignored commands leave
// the block ready for the next command. A read, or a tick during a frame, goes
// through the memory read register, then the output register; in_tready stays
// low until the output register, which out_tready can hold, takes the result.
// A fill writes one entry per cycle. pixel_count is written through
// cfg_we/cfg_wdata while the block is idle; a write during a frame is ignored.
module rgb_led_frame_store_serializer #(
  parameter int unsigned MAX_PIXELS = rlfs_pkg::MAX_PIXELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config: pixel_count
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,
  // command stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // pixel_index, red_in, green_in, blue_in
  input  wire logic [2:0]  in_tuser,   // kind
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [55:0] out_tdata,  // red_out, green_out, blue_out,
                                       // tx_first, tx_second, tx_third, tx_fourth
  output logic      [0:0]  out_tuser,  // result_type
  output logic             out_tlast   // frame_last
);

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [rlfs_pkg::PIXEL_W-1:0] ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [rlfs_pkg::PIXEL_W-1:0] ram_rdata;
  logic [rlfs_pkg::PIXEL_W-1:0] color;
  rlfs_pkg::rsp_req_t           rsp;
  logic                         rsp_ready;

  // store layout is red, green, blue from the top
  assign color = {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};

  rlfs_ctrl #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .kind       (in_tuser),
    .pixel_index(in_tdata[7:0]),
    .color      (color),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .rsp        (rsp),
    .rsp_ready  (rsp_ready)
  );

  // frame store
  rlfs_ram #(
    .WIDTH(rlfs_pkg::PIXEL_W),
    .DEPTH(MAX_PIXELS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // output register, formats readback and strand words
  rlfs_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp       (rsp),
    .rsp_ready (rsp_ready),
    .pixel     (ram_rdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/rlfs_ram.sv -----
`default_nettype none
module rlfs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rlfs_out.sv -----
`default_nettype none
module rlfs_out (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rlfs_pkg::rsp_req_t           rsp,
  output logic                              rsp_ready,
  input  wire logic [rlfs_pkg::PIXEL_W-1:0] pixel,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [55:0]                  out_tdata,
  output logic      [0:0]                   out_tuser,
  output logic                              out_tlast
);

  logic        out_valid_r;
  logic [55:0] data_r;
  logic        type_r;
  logic        last_r;
  logic [55:0] data_nxt;
  logic        type_nxt;
  logic        last_nxt;
  logic        take;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  flag;

  assign red   = pixel[23:16];
  assign green = pixel[15:8];
  assign blue  = pixel[7:0];
  assign flag  = {2'b11, ~blue[7:6], ~green[7:6], ~red[7:6]};

  assign rsp_ready = !out_valid_r || out_tready;
  assign take      = rsp.valid && rsp_ready;

  always_comb begin
    data_nxt = '0;
    type_nxt = rlfs_pkg::RESULT_TX_WORD;
    last_nxt = 1'b0;
    unique case (rsp.kind)
      rlfs_pkg::RSP_READBACK: begin
        type_nxt = rlfs_pkg::RESULT_READBACK;
        if (!rsp.black) begin
          data_nxt[23:0] = {blue, green, red};
        end
      end
      rlfs_pkg::RSP_PIXEL: begin
        data_nxt[55:24] = {red, green, blue, flag};
      end
      rlfs_pkg::RSP_ZERO: begin
        data_nxt = '0;
      end
      rlfs_pkg::RSP_LAST: begin
        last_nxt = 1'b1;
      end
      default: begin
        data_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
      type_r <= type_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = data_r;
  assign out_tuser[0] = type_r;
  assign out_tlast    = last_r;

endmodule
`default_nettype wire

// ----- rtl/rlfs_ctrl.sv -----
`default_nettype none
module rlfs_ctrl #(
  parameter int unsigned MAX_PIXELS = rlfs_pkg::MAX_PIXELS_DEF,
  localparam int unsigned AW        = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [rlfs_pkg::COUNT_W-1:0] cfg_wdata,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [2:0]                   kind,
  input  wire logic [7:0]                   pixel_index,
  input  wire logic [rlfs_pkg::PIXEL_W-1:0] color,
  output logic                              ram_we,
  output logic      [AW-1:0]                ram_waddr,
  output logic      [rlfs_pkg::PIXEL_W-1:0] ram_wdata,
  output logic                              ram_re,
  output logic      [AW-1:0]                ram_raddr,
  output rlfs_pkg::rsp_req_t                rsp,
  input  wire logic                         rsp_ready
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);
  localparam int unsigned COUNT_CAP   = (MAX_PIXELS < 511) ? MAX_PIXELS : 511;

  rlfs_pkg::state_t                 state_r, state_nxt;
  logic                             sending_r, sending_nxt;
  logic [rlfs_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [AW-1:0]                    cnt_r, cnt_nxt;
  logic [AW-1:0]                    end_r, end_nxt;
  logic [rlfs_pkg::PIXEL_W-1:0]     color_r, color_nxt;
  rlfs_pkg::rsp_kind_t              rsp_kind_r, rsp_kind_nxt;
  logic                             black_r, black_nxt;
  logic [rlfs_pkg::COUNT_W-1:0]     pixel_count_r;
  logic [rlfs_pkg::COUNT_W-1:0]     active_n;
  logic                             acc;
  logic                             idx_ok;
  logic                             pos_in_frame;

  assign active_n = (32'(pixel_count_r) > MAX_PIXELS) ? rlfs_pkg::COUNT_W'(COUNT_CAP)
                                                      : pixel_count_r;
  assign acc          = in_tvalid && in_tready;
  assign idx_ok       = 32'(pixel_index) < MAX_PIXELS;
  assign pos_in_frame = pos_r <= {1'b0, active_n};

  // next state
  always_comb begin
    state_nxt    = state_r;
    sending_nxt  = sending_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    end_nxt      = end_r;
    color_nxt    = color_r;
    rsp_kind_nxt = rsp_kind_r;
    black_nxt    = black_r;
    unique case (state_r)
      rlfs_pkg::ST_CLEAR, rlfs_pkg::ST_FILL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == end_r) begin
          state_nxt = rlfs_pkg::ST_IDLE;
        end
      end
      rlfs_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (kind)
            rlfs_pkg::KIND_READ: begin
              rsp_kind_nxt = rlfs_pkg::RSP_READBACK;
              black_nxt    = !idx_ok;
              state_nxt    = rlfs_pkg::ST_RESP;
            end
            rlfs_pkg::KIND_FILL: begin
              if (!sending_r && active_n != '0) begin
                cnt_nxt   = '0;
                end_nxt   = AW'(active_n - 1'b1);
                color_nxt = color;
                state_nxt = rlfs_pkg::ST_FILL;
              end
            end
            rlfs_pkg::KIND_START: begin
              if (!sending_r) begin
                sending_nxt = 1'b1;
                pos_nxt     = '0;
              end
            end
            rlfs_pkg::KIND_TICK: begin
              if (sending_r) begin
                state_nxt = rlfs_pkg::ST_RESP;
                black_nxt = 1'b0;
                if (pos_r == '0) begin
                  rsp_kind_nxt = rlfs_pkg::RSP_ZERO;
                  pos_nxt      = rlfs_pkg::POS_W'(1);
                end else if (pos_in_frame) begin
                  rsp_kind_nxt = rlfs_pkg::RSP_PIXEL;
                  pos_nxt      = pos_r + 1'b1;
                end else begin
                  rsp_kind_nxt = rlfs_pkg::RSP_LAST;
                  sending_nxt  = 1'b0;
                  pos_nxt      = '0;
                end
              end
            end
            default: begin
              state_nxt = rlfs_pkg::ST_IDLE;
            end
          endcase
        end
      end
      rlfs_pkg::ST_RESP: begin
        if (rsp_ready) begin
          state_nxt = rlfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rlfs_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = AW'(pixel_index);
    unique case (state_r)
      rlfs_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      rlfs_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = color_r;
      end
      rlfs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (acc && kind == rlfs_pkg::KIND_WRITE && !sending_r && idx_ok) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pixel_index);
          ram_wdata = color;
        end
        if (acc && kind == rlfs_pkg::KIND_READ) begin
          ram_re = 1'b1;
        end
        if (acc && kind == rlfs_pkg::KIND_TICK && sending_r && pos_r != '0 &&
            pos_in_frame) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(pos_r - 1'b1);
        end
      end
      rlfs_pkg::ST_RESP: begin
        in_tready = 1'b0;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // valid, kind, black
  assign rsp = {state_r == rlfs_pkg::ST_RESP, rsp_kind_r, black_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rlfs_pkg::ST_CLEAR;
      sending_r     <= 1'b0;
      pos_r         <= '0;
      cnt_r         <= '0;
      end_r         <= LAST_ADDR;
      pixel_count_r <= rlfs_pkg::PIXEL_COUNT_RST;
    end else begin
      state_r   <= state_nxt;
      sending_r <= sending_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      end_r     <= end_nxt;
      // a frame keeps its length once started
      if (cfg_we && !sending_r) begin
        pixel_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    color_r    <= color_nxt;
    rsp_kind_r <= rsp_kind_nxt;
    black_r    <= black_nxt;
  end

endmodule
`default_nettype wire

// ----- bench/tb_rgb_led_frame_store_serializer.sv -----
module tb_rgb_led_frame_store_serializer;

  // run limits and waits, in clock cycles
  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 300;   // enough for a full-strand fill to finish
  localparam int HOLD_LEN      = 400;   // long receiver hold-off
  localparam int STORE_DEPTH   = 256;
  localparam int MAX_REPORTS   = 20;
  localparam int RANDOM_BUDGET = 100;   // effective commands per pixel count

  // kinds the block must drop without a result
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  // one result transaction, fields in the order they are compared
  typedef struct packed {
    logic       rtype;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] tx_flag;
    logic [7:0] tx_blue;
    logic [7:0] tx_green;
    logic [7:0] tx_red;
    logic       last;
  } led_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [8:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // pixel_index, red_in, green_in, blue_in
  logic [2:0]  in_tuser   = '0;   // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;         // red_out, green_out, blue_out,
                                  // tx_first, tx_second, tx_third, tx_fourth
  logic [0:0]  out_tuser;         // result_type
  logic        out_tlast;         // frame_last

  // shadow of the block: frame store, frame sequencer and pixel count
  logic [23:0] frame_mem [STORE_DEPTH];
  bit          frame_active = 1'b0;
  int unsigned word_pos     = 0;
  logic [8:0]  pixel_count_q = rlfs_pkg::PIXEL_COUNT_RST;
  led_result_t expected_words [$];

  // traffic shaping
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int rx_hold_req  = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;

  // bookkeeping
  int errors       = 0;
  int useful_items = 0;
  int readbacks    = 0;
  int tx_words     = 0;
  int frames_done  = 0;
  int cycle_count  = 0;

  rgb_led_frame_store_serializer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // counts above the store depth are clamped
  function automatic int unsigned active_pixels();
    return (pixel_count_q > STORE_DEPTH) ? STORE_DEPTH : int'(pixel_count_q);
  endfunction

  // advance the shadow by one accepted command and queue the word it causes
  task automatic predict_cmd(input logic [2:0] kind, input logic [7:0] idx,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
    led_result_t res;
    logic [23:0] px;
    int unsigned n;
    int unsigned i;
    n   = active_pixels();
    res = '0;
    case (kind)
      rlfs_pkg::KIND_WRITE: begin
        // dropped while a frame is on the wire
        if (!frame_active) begin
          frame_mem[idx] = {r, g, b};
          useful_items++;
        end
      end
      rlfs_pkg::KIND_READ: begin
        // reads are answered even mid-frame
        px        = frame_mem[idx];
        res.rtype = rlfs_pkg::RESULT_READBACK;
        res.red   = px[23:16];
        res.green = px[15:8];
        res.blue  = px[7:0];
        expected_words.push_back(res);
        useful_items++;
      end
      rlfs_pkg::KIND_FILL: begin
        // a zero pixel count leaves the store alone
        if (!frame_active) begin
          for (i = 0; i < n; i++) frame_mem[8'(i)] = {r, g, b};
          useful_items++;
        end
      end
      rlfs_pkg::KIND_START: begin
        if (!frame_active) begin
          frame_active = 1'b1;
          word_pos     = 0;
          useful_items++;
        end
      end
      rlfs_pkg::KIND_TICK: begin
        // idle ticks produce nothing
        if (frame_active) begin
          res.rtype = rlfs_pkg::RESULT_TX_WORD;
          if (word_pos == 0) begin
            word_pos = 1;                     // opening zero word
          end else if (word_pos <= n) begin
            px           = frame_mem[8'(word_pos - 1)];
            // inverted top two bits of blue, green, red, top bits of flag set
            res.tx_flag  = {2'b11, ~px[7:6], ~px[15:14], ~px[23:22]};
            res.tx_blue  = px[7:0];
            res.tx_green = px[15:8];
            res.tx_red   = px[23:16];
            word_pos++;
          end else begin
            res.last     = 1'b1;              // closing zero word
            frame_active = 1'b0;
            word_pos     = 0;
          end
          expected_words.push_back(res);
          useful_items++;
        end
      end
      default: ;
    endcase
  endtask

  // offer one command, with an optional random gap first; valid stays high
  // between back-to-back transactions
  task automatic send_cmd(input logic [2:0] kind, input logic [7:0] idx,
                          input logic [7:0] r, input logic [7:0] g,
                          input logic [7:0] b);
    if ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r, idx};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    predict_cmd(kind, idx, r, g, b);
  endtask

  // sender pauses until every queued word has come back, then lets any
  // fill still running finish
  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only ever issued with the pipeline empty
  task automatic write_pixel_count(input logic [8:0] value);
    drain_results;
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    // a frame in progress keeps its length
    if (!frame_active) pixel_count_q = value;
  endtask

  // compare one accepted result against the oldest expected word
  task automatic check_word;
    led_result_t got;
    led_result_t want;
    got = {out_tuser[0], out_tdata[7:0], out_tdata[15:8], out_tdata[23:16],
           out_tdata[31:24], out_tdata[39:32], out_tdata[47:40], out_tdata[55:48],
           out_tlast};
    if (expected_words.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
    end else begin
      want = expected_words.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: mismatch expected type=%0d rgb=%h/%h/%h tx=%h/%h/%h/%h last=%0d",
                   $time, want.rtype, want.red, want.green, want.blue, want.tx_flag,
                   want.tx_blue, want.tx_green, want.tx_red, want.last);
          $display("%0t:          actual   type=%0d rgb=%h/%h/%h tx=%h/%h/%h/%h last=%0d",
                   $time, got.rtype, got.red, got.green, got.blue, got.tx_flag,
                   got.tx_blue, got.tx_green, got.tx_red, got.last);
        end
      end
      if (want.rtype == rlfs_pkg::RESULT_READBACK) readbacks++;
      else tx_words++;
      if (want.last) frames_done++;
    end
  endtask

  // receiver: check at the edge, then pick tready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_word();
    out_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= dst_idle_pct);
  end

  // hold-off counter, armed by bumping rx_hold_req
  always @(posedge clk) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= HOLD_LEN;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // store cleared at reset, color extremes, flag bit boundaries, dropped kinds
  task automatic test_clear_and_pixels;
    send_cmd(rlfs_pkg::KIND_READ, 8'd0, 8'h00, 8'h00, 8'h00);      // black after clear
    send_cmd(rlfs_pkg::KIND_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(rlfs_pkg::KIND_WRITE, 8'd255, 8'h3F, 8'h80, 8'hC0);
    send_cmd(rlfs_pkg::KIND_WRITE, 8'd128, 8'h40, 8'h7F, 8'hBF);
    send_cmd(rlfs_pkg::KIND_READ, 8'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(rlfs_pkg::KIND_READ, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(rlfs_pkg::KIND_READ, 8'd128, 8'h00, 8'h00, 8'h00);
    send_cmd(KIND_UNUSED_LO, 8'd1, 8'h11, 8'h22, 8'h33);
    send_cmd(KIND_UNUSED_HI, 8'd2, 8'h44, 8'h55, 8'h66);
    send_cmd(rlfs_pkg::KIND_TICK, 8'd0, 8'h00, 8'h00, 8'h00);       // idle tick
  endtask

  // three-pixel frame; write, fill, start and a count change mid-frame dropped
  task automatic test_short_frame;
    write_pixel_count(9'd3);
    send_cmd(rlfs_pkg::KIND_FILL, 8'd0, 8'h12, 8'h34, 8'h56);
    send_cmd(rlfs_pkg::KIND_WRITE, 8'd1, 8'hFF, 8'h00, 8'h80);
    send_cmd(rlfs_pkg::KIND_START, 8'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(rlfs_pkg::KIND_TICK, 8'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(rlfs_pkg::KIND_WRITE, 8'd2, 8'hAA, 8'hBB, 8'hCC);
    send_cmd(rlfs_pkg::KIND_FILL, 8'd0, 8'h01, 8'h02, 8'h03);
    send_cmd(rlfs_pkg::KIND_START, 8'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(rlfs_pkg::KIND_READ, 8'd2, 8'h00, 8'h00, 8'h00);
    repeat (3) send_cmd(rlfs_pkg::KIND_TICK, 8'd0, 8'h00, 8'h00, 8'h00);
    write_pixel_count(9'd9);                                        // frame in flight
    send_cmd(rlfs_pkg::KIND_TICK, 8'd0, 8'h00, 8'h00, 8'h00);       // closing word
  endtask

  // zero-length strand, then a count beyond the store depth
  task automatic test_count_extremes;
    write_pixel_count(9'd0);
    send_cmd(rlfs_pkg::KIND_FILL, 8'd0, 8'hEE, 8'hDD, 8'hCC);
    send_cmd(rlfs_pkg::KIND_READ, 8'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(rlfs_pkg::KIND_START, 8'd0, 8'h00, 8'h00, 8'h00);
    repeat (2) send_cmd(rlfs_pkg::KIND_TICK, 8'd0, 8'h00, 8'h00, 8'h00);
    write_pixel_count(9'd511);
    send_cmd(rlfs_pkg::KIND_FILL, 8'd0, 8'h9C, 8'h63, 8'hF0);
    send_cmd(rlfs_pkg::KIND_READ, 8'd255, 8'h00, 8'h00, 8'h00);
  endtask

  // receiver holds off while ticks and reads keep coming, so the block backs up
  task automatic test_output_backpressure;
    int k;
    src_idle_pct = 0;
    dst_idle_pct = 10;
    write_pixel_count(9'd40);
    send_cmd(rlfs_pkg::KIND_FILL, 8'd0, 8'h5A, 8'hC3, 8'h81);
    send_cmd(rlfs_pkg::KIND_WRITE, 8'd39, 8'h01, 8'hFE, 8'h7E);
    rx_hold_req++;
    send_cmd(rlfs_pkg::KIND_START, 8'd0, 8'h00, 8'h00, 8'h00);
    for (k = 0; k < 42; k++) begin
      if (k % 5 == 2) send_cmd(rlfs_pkg::KIND_READ, 8'(k), 8'h00, 8'h00, 8'h00);
      send_cmd(rlfs_pkg::KIND_TICK, 8'(k), 8'h00, 8'h00, 8'h00);
    end
    drain_results;
  endtask

  // random commands for one pixel count; runs until the frame in flight closes
  task automatic run_random(input int budget);
    int          target;
    int          pick;
    int unsigned n;
    logic [7:0]  idx;
    logic [2:0]  kind;
    target = useful_items + budget;
    while (useful_items < target || frame_active) begin
      n    = active_pixels();
      pick = $urandom_range(99);
      idx  = 8'($urandom_range(255));
      // mostly aim at pixels that are actually sent
      if (n > 0 && $urandom_range(9) < 6) idx = 8'($urandom_range(n - 1));
      if (frame_active) begin
        if      (pick < 80) kind = rlfs_pkg::KIND_TICK;
        else if (pick < 88) kind = rlfs_pkg::KIND_READ;
        else if (pick < 92) kind = rlfs_pkg::KIND_WRITE;
        else if (pick < 94) kind = rlfs_pkg::KIND_FILL;
        else if (pick < 97) kind = rlfs_pkg::KIND_START;
        else                kind = 3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      end else begin
        if      (pick < 42) kind = rlfs_pkg::KIND_WRITE;
        else if (pick < 66) kind = rlfs_pkg::KIND_READ;
        else if (pick < 69) kind = rlfs_pkg::KIND_FILL;
        else if (pick < 84) kind = rlfs_pkg::KIND_START;
        else if (pick < 92) kind = rlfs_pkg::KIND_TICK;
        else                kind = 3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      end
      send_cmd(kind, idx, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // one idling profile across three pixel counts
  task automatic test_random_traffic(input int src_pct, input int dst_pct,
                                     input logic [8:0] cnt_a, input logic [8:0] cnt_b,
                                     input logic [8:0] cnt_c);
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    write_pixel_count(cnt_a);
    run_random(RANDOM_BUDGET);
    write_pixel_count(cnt_b);
    run_random(RANDOM_BUDGET);
    write_pixel_count(cnt_c);
    run_random(RANDOM_BUDGET);
  endtask

  initial begin
    int i;
    for (i = 0; i < STORE_DEPTH; i++) frame_mem[8'(i)] = '0;
    src_idle_pct = 20;
    dst_idle_pct = 20;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_clear_and_pixels();
    test_short_frame();
    test_count_extremes();
    test_output_backpressure();
    test_random_traffic(7, 65, 9'd150, 9'd7, 9'd256);
    test_random_traffic(65, 7, 9'd1, 9'd0, 9'd300);
    test_random_traffic(0, 0, 9'd511, 9'd33, 9'd2);

    drain_results;
    $display("covered %0d effective commands: %0d readbacks, %0d transmit words, %0d frames",
             useful_items, readbacks, tx_words, frames_done);
    $display("pixel counts 0 to 511, mid-frame drops, long receiver hold-off, %0d errors",
             errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
